// File: sv/lsbse_pkg.sv
// ----------------------------------------------------------------------------
// LSB stego embed/extract package
// Shared payload types, register codes and constants for the stego block.
// ----------------------------------------------------------------------------
package lsbse_pkg;

   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [3:0] PadZeroReset = 4'd6;
   localparam logic [3:0] EndZeroReset = 4'd5;
   localparam logic [3:0] EndZeroMax   = 4'd5;
   localparam logic [2:0] HeldMax      = 3'd4;
   localparam logic [2:0] BitLast      = 3'd7;

   typedef enum logic {
      MODE_EMBED,
      MODE_EXTRACT
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE,
      CSR_PAD_ZERO_COUNT,
      CSR_END_ZERO_COUNT
   } csr_idx_type;

   typedef struct packed {
      logic       op;
      logic [7:0] carrier_byte;
      logic [7:0] message_byte;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data;
      logic       last;
      logic       need_byte;
      logic       done_res;
      logic       error;
   } rsp_type;

   // One queued request outcome: held zero bytes to send, then the final result
   typedef struct packed {
      logic [2:0] zeros;
      rsp_type    res;
   } slot_type;

endpackage

// File: sv/lsb_stego_embed_extract.sv
// ----------------------------------------------------------------------------
// LSB stego embed/extract
// Hides message bits in carrier LSBs, or recovers them, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: op 0 loads a message byte (or the end mark), op 1 hands in a
//   carrier byte. rsp channel: one result per request, except an extract
//   carrier that completes a nonzero byte, which gives the held zero bytes
//   (up to four) and then the byte, the final one flagged by last.
//   CSR port: mode, pad_zero_count, end_zero_count at byte addresses 0, 4, 8;
//   write them only while the block is idle.
// Flow and throughput:
//   A request is processed in the cycle it is accepted; its results are
//   written into the result queue, which feeds the rsp port. One request per
//   cycle is taken as long as results drain. A burst of results leaves in
//   order through the two-entry result queue between processing and rsp.
// Reset: clears the run state and the queue and loads the register defaults
//   (embed, six pad bytes, five end bytes).
// Stall: results wait in the queue; req_stall rises once both entries are in
//   use and drops the cycle after one frees up.
// ----------------------------------------------------------------------------
module lsb_stego_embed_extract (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  lsbse_pkg::req_type                       req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output lsbse_pkg::rsp_type                       rsp_payload,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [lsbse_pkg::CsrAddrWidth-1:0]       paddr,
   input  logic [lsbse_pkg::CsrDataWidth-1:0]       pwdata,
   output logic [lsbse_pkg::CsrDataWidth-1:0]       prdata,
   output logic                                     pready
);
   import lsbse_pkg::*;

   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // configuration
   mode_type   mode_ff;
   logic [3:0] pad_ff;
   logic [3:0] endc_ff;
   logic       csr_wr;

   // run state
   logic [2:0] bidx_ff, bidx_in;
   logic [7:0] work_ff, work_in;
   logic [3:0] zrun_ff, zrun_in;
   logic       src_ff, src_in;
   logic       fin_ff, fin_in;
   logic       loaded_ff, loaded_in;
   logic       seen_ff, seen_in;

   logic       req_accept;
   logic       rsp_accept;
   logic [3:0] pad_eff;
   logic [3:0] endc_eff;
   logic [3:0] zrun_inc;
   logic [7:0] shifted;
   slot_type   slot_new;

   // result queue
   slot_type             q_ff [QDepth];
   logic [QPtrW-1:0]     wr_ptr_ff;
   logic [QPtrW-1:0]     rd_ptr_ff;
   logic [QCntW-1:0]     count_ff;
   logic [2:0]           burst_ff;
   slot_type             head;
   logic                 zero_item;
   logic                 pop;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EMBED;
         pad_ff  <= PadZeroReset;
         endc_ff <= EndZeroReset;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            CSR_MODE:           mode_ff <= mode_type'(pwdata[0]);
            CSR_PAD_ZERO_COUNT: pad_ff  <= pwdata[3:0];
            CSR_END_ZERO_COUNT: endc_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_MODE:           prdata = {{(CsrDataWidth-1){1'b0}}, mode_ff};
         CSR_PAD_ZERO_COUNT: prdata = {{(CsrDataWidth-4){1'b0}}, pad_ff};
         CSR_END_ZERO_COUNT: prdata = {{(CsrDataWidth-4){1'b0}}, endc_ff};
         default:            prdata = '0;
      endcase
   end

   assign req_stall  = (count_ff == QCntW'(QDepth));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign pad_eff  = (pad_ff == 4'd0) ? 4'd1 : pad_ff;
   assign endc_eff = (endc_ff == 4'd0) ? 4'd1 :
                     (endc_ff > EndZeroMax) ? EndZeroMax : endc_ff;
   assign zrun_inc = zrun_ff + 4'd1;
   assign shifted  = {work_ff[6:0], req_payload.carrier_byte[0]};

   always_comb begin
      bidx_in   = bidx_ff;
      work_in   = work_ff;
      zrun_in   = zrun_ff;
      src_in    = src_ff;
      fin_in    = fin_ff;
      loaded_in = loaded_ff;
      seen_in   = seen_ff;
      slot_new  = '0;
      slot_new.res.last = 1'b1;
      if (mode_ff == MODE_EMBED) begin
         if (!req_payload.op) begin
            if (!fin_ff && !src_ff && !loaded_ff) begin
               if (req_payload.message_end) begin
                  if (seen_ff) begin
                     src_in    = 1'b1;
                     work_in   = 8'd0;
                     loaded_in = 1'b1;
                     zrun_in   = 4'd0;
                     bidx_in   = 3'd0;
                  end else begin
                     slot_new.res.error = 1'b1;
                  end
               end else begin
                  work_in   = req_payload.message_byte;
                  loaded_in = 1'b1;
                  seen_in   = 1'b1;
                  bidx_in   = 3'd0;
               end
            end
         end else if (fin_ff || !loaded_ff) begin
            // pass the carrier through; flag it if nothing was loaded
            slot_new.res.data_valid = 1'b1;
            slot_new.res.data       = req_payload.carrier_byte;
            slot_new.res.error      = !fin_ff;
         end else begin
            slot_new.res.data_valid = 1'b1;
            slot_new.res.data = {req_payload.carrier_byte[7:1], work_ff[BitLast - bidx_ff]};
            bidx_in = bidx_ff + 3'd1;
            if (bidx_ff == BitLast) begin
               if (src_ff) begin
                  zrun_in = zrun_inc;
                  work_in = 8'd0;
                  if (zrun_inc >= pad_eff) begin
                     fin_in = 1'b1;
                  end
               end else begin
                  loaded_in = 1'b0;
               end
            end
         end
      end else if (req_payload.op && !fin_ff) begin
         work_in = shifted;
         bidx_in = bidx_ff + 3'd1;
         if (bidx_ff == BitLast) begin
            work_in = 8'd0;
            if (shifted == 8'd0) begin
               zrun_in = zrun_inc;
               if (zrun_inc >= endc_eff) begin
                  fin_in = 1'b1;
               end
            end else begin
               // release the held zero bytes ahead of this one
               slot_new.zeros = (zrun_ff > 4'(HeldMax)) ? HeldMax : zrun_ff[2:0];
               zrun_in = 4'd0;
               slot_new.res.data_valid = 1'b1;
               slot_new.res.data       = shifted;
            end
         end
      end
      slot_new.res.need_byte = (mode_ff == MODE_EMBED) && !fin_in && !src_in && !loaded_in;
      slot_new.res.done_res  = fin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff   <= '0;
         work_ff   <= '0;
         zrun_ff   <= '0;
         src_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         loaded_ff <= 1'b0;
         seen_ff   <= 1'b0;
      end else if (req_accept) begin
         bidx_ff   <= bidx_in;
         work_ff   <= work_in;
         zrun_ff   <= zrun_in;
         src_ff    <= src_in;
         fin_ff    <= fin_in;
         loaded_ff <= loaded_in;
         seen_ff   <= seen_in;
      end
   end

   assign head      = q_ff[rd_ptr_ff];
   assign zero_item = (burst_ff != head.zeros);
   assign pop       = rsp_accept && !zero_item;

   always_comb begin
      rsp_payload = head.res;
      if (zero_item) begin
         rsp_payload.data_valid = 1'b1;
         rsp_payload.data       = 8'd0;
         rsp_payload.last       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_ff[wr_ptr_ff] <= slot_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         burst_ff  <= '0;
      end else begin
         if (req_accept) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
            burst_ff  <= '0;
         end else if (rsp_accept) begin
            burst_ff  <= burst_ff + 3'd1;
         end
         count_ff <= count_ff + QCntW'(req_accept) - QCntW'(pop);
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntW'(QDepth))
      else $error("result queue overfilled");

   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> burst_ff <= head.zeros)
      else $error("held zero burst overran its count");

   a_done_no_need: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res |-> !rsp_payload.need_byte)
      else $error("need_byte raised after the run finished");

   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> fin_ff)
      else $error("finished flag dropped without reset");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LSB stego embed/extract testbench
// Drives carrier and message requests in both modes and predicts every
// result in step. Results are checked field by field, in order. Random
// result stalls and request gaps, register writes between phases, one padding
// run and one terminator run.
// ----------------------------------------------------------------------------
module tb_top;
   import lsbse_pkg::*;

   localparam int HalfPeriod  = 5;
   localparam int ResetCycles = 12;
   localparam int BurstMaxLen = 19;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_payload;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   // Predicted register and run state
   mode_type   cfg_mode      = MODE_EMBED;
   logic [3:0] cfg_pad       = PadZeroReset;
   logic [3:0] cfg_end       = EndZeroReset;
   logic [3:0] bit_idx       = '0;
   logic [7:0] shift_byte    = '0;
   logic [3:0] zero_run      = '0;
   bit         source_ended  = 1'b0;
   bit         run_finished  = 1'b0;
   bit         byte_loaded   = 1'b0;
   bit         any_byte_seen = 1'b0;

   rsp_type pending_results[$];
   int      mismatch_count = 0;
   bit      idle_enable    = 1'b1;
   int      stall_left     = 0;

   lsb_stego_embed_extract uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #HalfPeriod clock = ~clock;

   // Result-side back pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!reset && idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, BurstMaxLen - 1);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [3:0] end_limit();
      logic [3:0] lim;
      lim = (cfg_end == 4'd0) ? 4'd1 : cfg_end;
      return (lim > EndZeroMax) ? EndZeroMax : lim;
   endfunction

   function automatic rsp_type status_rsp(logic dv, logic [7:0] d, logic err);
      rsp_type r;
      r.data_valid = dv;
      r.data       = d;
      r.last       = 1'b0;
      r.need_byte  = (cfg_mode == MODE_EMBED) && !run_finished && !source_ended
                     && !byte_loaded;
      r.done_res   = run_finished;
      r.error      = err;
      return r;
   endfunction

   task automatic predict_stego(input req_type r);
      rsp_type    burst[$];
      logic       err;
      logic [3:0] pad_eff;
      logic [7:0] stego_byte;
      logic [7:0] done_byte;
      int         held;
      err = 1'b0;
      if (cfg_mode == MODE_EMBED) begin
         if (r.op == 1'b0) begin
            if (!run_finished && !source_ended && !byte_loaded) begin
               if (r.message_end) begin
                  if (any_byte_seen) begin
                     source_ended = 1'b1;
                     shift_byte   = '0;
                     byte_loaded  = 1'b1;
                     zero_run     = '0;
                     bit_idx      = '0;
                  end else begin
                     err = 1'b1;
                  end
               end else begin
                  shift_byte    = r.message_byte;
                  byte_loaded   = 1'b1;
                  any_byte_seen = 1'b1;
                  bit_idx       = '0;
               end
            end
            burst = {burst, status_rsp(1'b0, 8'h00, err)};
         end else if (run_finished) begin
            burst = {burst, status_rsp(1'b1, r.carrier_byte, 1'b0)};
         end else if (!byte_loaded) begin
            burst = {burst, status_rsp(1'b1, r.carrier_byte, 1'b1)};
         end else begin
            pad_eff    = (cfg_pad == 4'd0) ? 4'd1 : cfg_pad;
            stego_byte = {r.carrier_byte[7:1], shift_byte[BitLast - bit_idx[2:0]]};
            bit_idx    = {1'b0, bit_idx[2:0]} + 4'd1;
            if (bit_idx >= 4'd8) begin
               bit_idx = '0;
               if (source_ended) begin
                  zero_run   = zero_run + 4'd1;
                  shift_byte = '0;
                  if (zero_run >= pad_eff) run_finished = 1'b1;
               end else begin
                  byte_loaded = 1'b0;
               end
            end
            burst = {burst, status_rsp(1'b1, stego_byte, 1'b0)};
         end
      end else begin
         if (r.op == 1'b0 || run_finished) begin
            burst = {burst, status_rsp(1'b0, 8'h00, 1'b0)};
         end else begin
            shift_byte = {shift_byte[6:0], r.carrier_byte[0]};
            bit_idx    = {1'b0, bit_idx[2:0]} + 4'd1;
            if (bit_idx < 4'd8) begin
               burst = {burst, status_rsp(1'b0, 8'h00, 1'b0)};
            end else begin
               done_byte  = shift_byte;
               bit_idx    = '0;
               shift_byte = '0;
               if (done_byte == 8'h00) begin
                  zero_run = zero_run + 4'd1;
                  if (zero_run >= end_limit()) run_finished = 1'b1;
                  burst = {burst, status_rsp(1'b0, 8'h00, 1'b0)};
               end else begin
                  // release held zeros, capped by the burst size
                  held     = (zero_run > HeldMax) ? HeldMax : zero_run;
                  zero_run = '0;
                  repeat (held) burst = {burst, status_rsp(1'b1, 8'h00, 1'b0)};
                  burst = {burst, status_rsp(1'b1, done_byte, 1'b0)};
               end
            end
         end
      end
      burst[burst.size() - 1].last = 1'b1;
      pending_results = {pending_results, burst};
   endtask

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("data_valid", want.data_valid, rsp_payload.data_valid);
            check_field("data", want.data, rsp_payload.data);
            check_field("last", want.last, rsp_payload.last);
            check_field("need_byte", want.need_byte, rsp_payload.need_byte);
            check_field("done_res", want.done_res, rsp_payload.done_res);
            check_field("error", want.error, rsp_payload.error);
         end
      end
   end

   task automatic push_request(input logic op, input logic [7:0] carrier,
                               input logic [7:0] msg, input logic msg_end);
      req_type r;
      int      gap;
      r.op           = op;
      r.carrier_byte = carrier;
      r.message_byte = msg;
      r.message_end  = msg_end;
      gap = (idle_enable && $urandom_range(0, 7) == 0) ? $urandom_range(1, BurstMaxLen) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_stego(r);
   endtask

   task automatic send_carrier(input logic [7:0] carrier);
      push_request(1'b1, carrier, 8'($urandom), 1'($urandom));
   endtask

   task automatic send_load(input logic [7:0] msg, input logic msg_end);
      push_request(1'b0, 8'($urandom), msg, msg_end);
   endtask

   // Spread one byte over eight carrier LSBs, MSB first
   task automatic send_hidden_byte(input logic [7:0] b);
      int i;
      for (i = 7; i >= 0; i--) send_carrier({7'($urandom), b[i]});
   endtask

   // Finish a partial extract byte with ones so it cannot count as a zero
   task automatic align_extract();
      while (bit_idx != 4'd0) send_carrier({7'($urandom), 1'b1});
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] nonzero_byte();
      logic [7:0] b;
      b = rand_byte();
      return (b == 8'h00) ? 8'h80 : b;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [31:0] value);
      logic [31:0] expected;
      wait_drained();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         CSR_MODE: begin
            cfg_mode = mode_type'(value[0]);
            expected = {31'b0, cfg_mode};
         end
         CSR_PAD_ZERO_COUNT: begin
            cfg_pad  = value[3:0];
            expected = {28'b0, cfg_pad};
         end
         CSR_END_ZERO_COUNT: begin
            cfg_end  = value[3:0];
            expected = {28'b0, cfg_end};
         end
         default: expected = '0;
      endcase
      // read back through a fresh setup phase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      check_field("register readback", expected, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_embed_directed();
      int i;
      send_carrier(8'hFF);
      send_carrier(8'h00);
      send_load(8'h00, 1'b1);   // end mark with nothing sent yet
      send_load(8'hA5, 1'b0);
      send_load(8'h5A, 1'b0);   // dropped, byte still loaded
      send_load(8'hFF, 1'b1);
      for (i = 0; i < 8; i++) send_carrier(i[0] ? 8'hFF : 8'h00);
   endtask

   task automatic test_extract_directed();
      csr_write(CSR_MODE, MODE_EXTRACT);
      csr_write(CSR_END_ZERO_COUNT, 32'd3);
      send_load(8'hFF, 1'b1);
      send_hidden_byte(8'h00);
      send_hidden_byte(8'hFF);
   endtask

   task automatic test_embed_random();
      int phase;
      csr_write(CSR_MODE, MODE_EMBED);
      for (phase = 0; phase < 3; phase++) begin
         idle_enable = (phase != 1);
         case (phase)
            0: csr_write(CSR_PAD_ZERO_COUNT, 32'd0);
            1: csr_write(CSR_PAD_ZERO_COUNT, 32'd8);
            default: csr_write(CSR_PAD_ZERO_COUNT, $urandom_range(1, 15));
         endcase
         repeat (20) begin
            if (!byte_loaded) begin
               if ($urandom_range(0, 9) == 0) send_carrier(8'($urandom));
               else send_load(rand_byte(), 1'b0);
            end else if ($urandom_range(0, 9) == 0) begin
               send_load(8'($urandom), 1'($urandom));
            end else begin
               send_carrier(8'($urandom));
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_mode_switch();
      if (!byte_loaded) send_load(rand_byte(), 1'b0);
      repeat (3) send_carrier(8'($urandom));
      csr_write(CSR_MODE, MODE_EXTRACT);
      align_extract();
   endtask

   task automatic test_extract_random();
      int phase;
      int k;
      for (phase = 0; phase < 5; phase++) begin
         idle_enable = (phase != 3);
         case (phase)
            0: csr_write(CSR_END_ZERO_COUNT, 32'd8);
            1: csr_write(CSR_END_ZERO_COUNT, 32'd0);
            2: csr_write(CSR_END_ZERO_COUNT, 32'd2);
            3: csr_write(CSR_END_ZERO_COUNT, 32'd15);
            default: csr_write(CSR_END_ZERO_COUNT, $urandom_range(1, 15));
         endcase
         align_extract();
         for (k = 0; k < 3; k++) begin
            if (phase == 1 && k == 2) wait_drained();
            if ($urandom_range(0, 5) == 0) send_load(8'($urandom), 1'($urandom));
            // keep the zero run short of the terminator
            if (zero_run + 1 < end_limit() && $urandom_range(0, 1) == 0)
               send_hidden_byte(8'h00);
            else
               send_hidden_byte(nonzero_byte());
         end
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_embed_padding();
      csr_write(CSR_MODE, MODE_EMBED);
      csr_write(CSR_PAD_ZERO_COUNT, 32'd15);
      while (byte_loaded) send_carrier(8'($urandom));
      send_load(rand_byte(), 1'b1);
      send_load(rand_byte(), 1'b0);   // dropped once the source has ended
      // stop one pad byte short of done
      repeat (14 * 8) send_carrier(8'($urandom));
   endtask

   task automatic test_terminator();
      csr_write(CSR_MODE, MODE_EXTRACT);
      csr_write(CSR_END_ZERO_COUNT, 32'd8);
      send_hidden_byte(nonzero_byte());
      repeat (4) send_hidden_byte(8'h00);
      send_hidden_byte(nonzero_byte());
      repeat (5) send_hidden_byte(8'h00);
   endtask

   task automatic test_after_finish();
      int pass_idx;
      idle_enable = 1'b0;
      for (pass_idx = 0; pass_idx < 2; pass_idx++) begin
         csr_write(CSR_MODE, pass_idx == 0 ? MODE_EMBED : MODE_EXTRACT);
         csr_write(CSR_PAD_ZERO_COUNT, $urandom_range(0, 15));
         csr_write(CSR_END_ZERO_COUNT, $urandom_range(0, 15));
         repeat (20) push_request(1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_embed_directed();
      test_extract_directed();
      test_embed_random();
      test_mode_switch();
      test_extract_random();
      test_embed_padding();
      test_terminator();
      test_after_finish();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
sv/lsbse_pkg.sv
sv/lsb_stego_embed_extract.sv
dv/tb_top.sv
